### rtl/ctpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic trajectory PD controller package
// Shared widths, register indexes, reset values and sideband types.
// ----------------------------------------------------------------------------
package ctpd_pkg;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int TIME_W    = 24;
  localparam int POS_W     = 24;
  localparam int TORQUE_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KV       = 3'd4;

  localparam logic [CFG_W-1:0] RST_DURATION = 24'd40960;
  localparam logic [CFG_W-1:0] RST_START    = 24'd0;
  localparam logic [CFG_W-1:0] RST_TARGET   = 24'd205887;
  localparam logic [CFG_W-1:0] RST_KP       = 24'd409600;
  localparam logic [CFG_W-1:0] RST_KV       = 24'd40960;

  localparam int FRAC_S   = 24;
  localparam int S_W      = 25;
  localparam int G_W      = 23;
  localparam int H_W      = 25;
  localparam int DIST_W   = 25;
  localparam int DIST6_W  = 28;
  localparam int NUM_W    = 52;
  localparam int VQ_W     = 38;
  localparam int VREF_W   = 39;
  localparam int DH_W     = 51;
  localparam int RND_W    = 27;
  localparam int EP_W     = 25;
  localparam int EV_W     = 40;
  localparam int EV_LO_W  = 20;
  localparam int ACC_W    = 64;
  localparam int GAIN_FR  = 12;

  localparam logic [S_W-1:0] ONE_Q24 = 25'h1000000;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
    logic                    past;
  } ctpd_side1_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
    logic                    past;
    logic [H_W-1:0]          h;
    logic                    neg;
  } ctpd_side2_t;

endpackage

### rtl/ctpd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined long divider
// Restoring division, one quotient bit per stage, with a sideband that
// travels alongside. The dividend must be below divisor * 2^QUO_W.
// ----------------------------------------------------------------------------
module ctpd_div #(
  parameter int DVS_W  = ctpd_pkg::CFG_W,
  parameter int QUO_W  = ctpd_pkg::S_W,
  parameter int SIDE_W = $bits(ctpd_pkg::ctpd_side1_t)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [DVS_W+QUO_W-1:0] in_dividend,
  input  logic [SIDE_W-1:0]      in_side,
  input  logic [DVS_W-1:0]       divisor,
  output logic                   out_vld,
  output logic [QUO_W-1:0]       out_quot,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int WORK_W = DVS_W + QUO_W;

  logic [WORK_W-1:0] work_r   [QUO_W];
  logic [WORK_W-1:0] work_nxt [QUO_W];
  logic [WORK_W-1:0] src_work [QUO_W];
  logic [SIDE_W-1:0] side_r   [QUO_W];
  logic [SIDE_W-1:0] side_nxt [QUO_W];
  logic [QUO_W-1:0]  vld_r;
  logic [QUO_W-1:0]  vld_nxt;

  always_comb begin
    src_work[0] = in_dividend;
    side_nxt[0] = in_side;
    for (int k = 1; k < QUO_W; k++) begin
      src_work[k] = work_r[k-1];
      side_nxt[k] = side_r[k-1];
    end
  end

  always_comb begin
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    for (int k = 0; k < QUO_W; k++) begin
      trial = src_work[k][WORK_W-1 -: DVS_W+1];
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
        work_nxt[k] = {diff[DVS_W-1:0], src_work[k][QUO_W-2:0], 1'b1};
      end else begin
        work_nxt[k] = {trial[DVS_W-1:0], src_work[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  assign vld_nxt = {vld_r[QUO_W-2:0], in_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        work_r[k] <= work_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quot = work_r[QUO_W-1][QUO_W-1:0];
  assign out_side = side_r[QUO_W-1];

endmodule

### rtl/cubic_trajectory_pd_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic trajectory PD controller
// Each input beat carries a sample time, a measured joint angle and a
// measured joint velocity; each produces one torque beat with a clip flag.
//
// Channels: in_* and out_* use valid/ready; cfg_* is a plain write port
// (cfg_wr_en, cfg_index, cfg_wdata) that must be written only while idle;
// the block itself does not enforce this. Throughput is one beat per clock
// when the receiver does not stall. The pipeline is built around two
// long-division pipelines of one quotient bit per stage: 25 stages for the
// normalized time and 38 stages for the reference velocity, with the
// multiply and rounding stages around them. Reset empties the pipeline and
// loads the default duration, positions and gains. A two-entry output
// buffer sits at the end; when the receiver stalls and the buffer fills,
// the whole pipeline holds and in_ready drops, and no beat is lost or
// repeated.
// ----------------------------------------------------------------------------
module cubic_trajectory_pd_controller_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ctpd_pkg::TIME_W-1:0]           in_sample_time,
  input  logic signed [ctpd_pkg::POS_W-1:0]     in_measured_position,
  input  logic signed [ctpd_pkg::POS_W-1:0]     in_measured_velocity,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ctpd_pkg::TORQUE_W-1:0]  out_torque,
  output logic                                  out_saturated,
  input  logic                                  cfg_wr_en,
  input  logic [ctpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctpd_pkg::CFG_W-1:0]            cfg_wdata
);

  import ctpd_pkg::*;

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_FULL  = 2'd2;

  // Configuration and derived constants.
  logic [CFG_W-1:0]          dur_r;
  logic signed [POS_W-1:0]   start_r;
  logic signed [POS_W-1:0]   target_r;
  logic [CFG_W-1:0]          kp_r;
  logic [CFG_W-1:0]          kv_r;
  logic signed [DIST_W-1:0]  dist_r;
  logic signed [DIST_W-1:0]  dist_nxt;
  logic signed [DIST6_W-1:0] dist6_r;
  logic signed [DIST6_W-1:0] dist6_nxt;

  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r    <= RST_DURATION;
      start_r  <= RST_START;
      target_r <= RST_TARGET;
      kp_r     <= RST_KP;
      kv_r     <= RST_KV;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DURATION: dur_r    <= cfg_wdata;
        REG_START:    start_r  <= cfg_wdata;
        REG_TARGET:   target_r <= cfg_wdata;
        REG_KP:       kp_r     <= cfg_wdata;
        REG_KV:       kv_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dist_nxt  = DIST_W'(target_r) - DIST_W'(start_r);
  assign dist6_nxt = (DIST6_W'(target_r) - DIST6_W'(start_r)) * DIST6_W'(6);

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    dist6_r <= dist6_nxt;
  end

  // Input stage.
  logic              a_vld_r;
  logic [TIME_W-1:0] a_t_r;
  ctpd_side1_t       a_side_r;
  ctpd_side1_t       a_side_nxt;

  always_comb begin
    a_side_nxt.pos  = in_measured_position;
    a_side_nxt.vel  = in_measured_velocity;
    a_side_nxt.past = (dur_r == '0) || (in_sample_time > dur_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_t_r    <= in_sample_time;
      a_side_r <= a_side_nxt;
    end
  end

  // Normalized time s = t * 2^24 / T.
  logic                          dv1_vld;
  logic [S_W-1:0]                dv1_s;
  logic [$bits(ctpd_side1_t)-1:0] dv1_side_raw;
  ctpd_side1_t                   dv1_side;

  ctpd_div #(
    .DVS_W  (CFG_W),
    .QUO_W  (S_W),
    .SIDE_W ($bits(ctpd_side1_t))
  ) u_div_time (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (a_vld_r),
    .in_dividend ({1'b0, a_t_r, {FRAC_S{1'b0}}}),
    .in_side     (a_side_r),
    .divisor     (dur_r),
    .out_vld     (dv1_vld),
    .out_quot    (dv1_s),
    .out_side    (dv1_side_raw)
  );

  assign dv1_side = ctpd_side1_t'(dv1_side_raw);

  // Stage S1: s^2 and s*(1-s).
  logic             s1_vld_r;
  logic [S_W-1:0]   s1_s_r;
  logic [S_W-1:0]   s1_s2_r;
  logic [G_W-1:0]   s1_g_r;
  ctpd_side1_t      s1_side_r;
  logic [2*S_W-1:0] s1_ss;
  logic [2*S_W-1:0] s1_gg;
  logic [S_W-1:0]   s1_s2_nxt;
  logic [G_W-1:0]   s1_g_nxt;

  always_comb begin
    s1_ss     = dv1_s * dv1_s;
    s1_gg     = dv1_s * (ONE_Q24 - dv1_s);
    s1_s2_nxt = s1_ss[2*FRAC_S:FRAC_S];
    s1_g_nxt  = s1_gg[FRAC_S+G_W-1:FRAC_S];
  end

  // Stage S2: s^3 and 6*d*g.
  logic                    s2_vld_r;
  logic [S_W-1:0]          s2_s2_r;
  logic [S_W-1:0]          s2_s3_r;
  logic signed [NUM_W-1:0] s2_num_r;
  ctpd_side1_t             s2_side_r;
  logic [2*S_W-1:0]        s2_sss;
  logic [S_W-1:0]          s2_s3_nxt;
  logic signed [NUM_W-1:0] s2_num_nxt;

  always_comb begin
    s2_sss     = s1_s2_r * s1_s_r;
    s2_s3_nxt  = s2_sss[2*FRAC_S:FRAC_S];
    s2_num_nxt = dist6_r * $signed({1'b0, s1_g_r});
  end

  // Stage S3: h = 3s^2 - 2s^3 and the divider numerator for the velocity.
  logic              s3_vld_r;
  logic [VQ_W-1:0]   s3_a_r;
  ctpd_side2_t       s3_side_r;
  logic [H_W+1:0]    s3_h_full;
  logic [NUM_W-1:0]  s3_half;
  logic [NUM_W-1:0]  s3_sum;
  logic [VQ_W-1:0]   s3_a_nxt;
  ctpd_side2_t       s3_side_nxt;

  always_comb begin
    s3_h_full = ({2'b00, s2_s2_r} + {1'b0, s2_s2_r, 1'b0}) - {1'b0, s2_s3_r, 1'b0};
    s3_half   = NUM_W'({dur_r, {(GAIN_FR-1){1'b0}}});
    if (s2_num_r[NUM_W-1]) begin
      s3_sum = s3_half - NUM_W'(s2_num_r);
    end else begin
      s3_sum = NUM_W'(s2_num_r) + s3_half;
    end
    s3_a_nxt         = s3_sum[VQ_W+GAIN_FR-1:GAIN_FR];
    s3_side_nxt.pos  = s2_side_r.pos;
    s3_side_nxt.vel  = s2_side_r.vel;
    s3_side_nxt.past = s2_side_r.past;
    s3_side_nxt.h    = s3_h_full[H_W-1:0];
    s3_side_nxt.neg  = s2_num_r[NUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= dv1_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r    <= dv1_s;
      s1_s2_r   <= s1_s2_nxt;
      s1_g_r    <= s1_g_nxt;
      s1_side_r <= dv1_side;
      s2_s2_r   <= s1_s2_r;
      s2_s3_r   <= s2_s3_nxt;
      s2_num_r  <= s2_num_nxt;
      s2_side_r <= s1_side_r;
      s3_a_r    <= s3_a_nxt;
      s3_side_r <= s3_side_nxt;
    end
  end

  // Reference velocity magnitude = round(|6*d*g| / (T * 2^12)).
  logic                           dv2_vld;
  logic [VQ_W-1:0]                dv2_q;
  logic [$bits(ctpd_side2_t)-1:0] dv2_side_raw;
  ctpd_side2_t                    dv2_side;

  ctpd_div #(
    .DVS_W  (CFG_W),
    .QUO_W  (VQ_W),
    .SIDE_W ($bits(ctpd_side2_t))
  ) u_div_vel (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (s3_vld_r),
    .in_dividend ({{CFG_W{1'b0}}, s3_a_r}),
    .in_side     (s3_side_r),
    .divisor     (dur_r),
    .out_vld     (dv2_vld),
    .out_quot    (dv2_q),
    .out_side    (dv2_side_raw)
  );

  assign dv2_side = ctpd_side2_t'(dv2_side_raw);

  // Stage D1: signed velocity and d*h.
  logic                     d1_vld_r;
  logic signed [VREF_W-1:0] d1_vref_r;
  logic signed [DH_W-1:0]   d1_dh_r;
  ctpd_side1_t              d1_side_r;
  logic signed [VREF_W-1:0] d1_q_ext;
  logic signed [VREF_W-1:0] d1_vref_nxt;
  logic signed [DH_W-1:0]   d1_dh_nxt;
  ctpd_side1_t              d1_side_nxt;

  always_comb begin
    d1_q_ext         = $signed({1'b0, dv2_q});
    d1_vref_nxt      = dv2_side.neg ? -d1_q_ext : d1_q_ext;
    d1_dh_nxt        = dist_r * $signed({1'b0, dv2_side.h});
    d1_side_nxt.pos  = dv2_side.pos;
    d1_side_nxt.vel  = dv2_side.vel;
    d1_side_nxt.past = dv2_side.past;
  end

  // Stage D2: round d*h to the position grid.
  logic                     d2_vld_r;
  logic signed [VREF_W-1:0] d2_vref_r;
  logic signed [RND_W-1:0]  d2_rnd_r;
  ctpd_side1_t              d2_side_r;
  logic signed [DH_W-1:0]   d2_dh_rnd;
  logic signed [RND_W-1:0]  d2_rnd_nxt;

  always_comb begin
    d2_dh_rnd  = d1_dh_r + (DH_W'(1) <<< (FRAC_S - 1));
    d2_rnd_nxt = $signed(d2_dh_rnd[DH_W-1:FRAC_S]);
  end

  // Stage D3: position and velocity errors.
  logic                     d3_vld_r;
  logic signed [EP_W-1:0]   d3_ep_r;
  logic signed [EV_W-1:0]   d3_ev_r;
  logic signed [RND_W:0]    d3_pref;
  logic signed [RND_W:0]    d3_ep_full;
  logic signed [EP_W-1:0]   d3_ep_nxt;
  logic signed [EV_W-1:0]   d3_ev_nxt;

  always_comb begin
    if (d2_side_r.past) begin
      d3_pref   = (RND_W+1)'(target_r);
      d3_ev_nxt = -EV_W'(d2_side_r.vel);
    end else begin
      d3_pref   = (RND_W+1)'(start_r) + (RND_W+1)'(d2_rnd_r);
      d3_ev_nxt = EV_W'(d2_vref_r) - EV_W'(d2_side_r.vel);
    end
    d3_ep_full = d3_pref - (RND_W+1)'(d2_side_r.pos);
    d3_ep_nxt  = $signed(d3_ep_full[EP_W-1:0]);
  end

  // Stage D4: gain products, the velocity term split into two halves.
  logic                                  d4_vld_r;
  logic signed [EP_W+CFG_W:0]            d4_pp_r;
  logic signed [EV_LO_W+CFG_W+1:0]       d4_pvl_r;
  logic signed [EV_W-EV_LO_W+CFG_W:0]    d4_pvh_r;
  logic signed [EP_W+CFG_W:0]            d4_pp_nxt;
  logic signed [EV_LO_W+CFG_W+1:0]       d4_pvl_nxt;
  logic signed [EV_W-EV_LO_W+CFG_W:0]    d4_pvh_nxt;

  always_comb begin
    d4_pp_nxt  = $signed({1'b0, kp_r}) * d3_ep_r;
    d4_pvl_nxt = $signed({1'b0, kv_r}) * $signed({1'b0, d3_ev_r[EV_LO_W-1:0]});
    d4_pvh_nxt = $signed({1'b0, kv_r}) * $signed(d3_ev_r[EV_W-1:EV_LO_W]);
  end

  // Stage D5: accumulate.
  logic                    d5_vld_r;
  logic signed [ACC_W-1:0] d5_acc_r;
  logic signed [ACC_W-1:0] d5_acc_nxt;

  always_comb begin
    d5_acc_nxt = ACC_W'(d4_pp_r) + ACC_W'(d4_pvl_r) + (ACC_W'(d4_pvh_r) <<< EV_LO_W);
  end

  // Stage D6: round and saturate.
  logic                       d6_vld_r;
  logic signed [TORQUE_W-1:0] d6_torque_r;
  logic                       d6_sat_r;
  logic signed [ACC_W-1:0]    d6_rnd;
  logic [ACC_W-TORQUE_W-GAIN_FR:0] d6_hi;
  logic                       d6_sat_nxt;
  logic signed [TORQUE_W-1:0] d6_torque_nxt;

  always_comb begin
    d6_rnd     = d5_acc_r + (ACC_W'(1) <<< (GAIN_FR - 1));
    d6_hi      = d6_rnd[ACC_W-1:TORQUE_W+GAIN_FR-1];
    d6_sat_nxt = !((&d6_hi) || !(|d6_hi));
    if (d6_sat_nxt) begin
      d6_torque_nxt = d6_rnd[ACC_W-1] ? {1'b1, {(TORQUE_W-1){1'b0}}}
                                      : {1'b0, {(TORQUE_W-1){1'b1}}};
    end else begin
      d6_torque_nxt = $signed(d6_rnd[TORQUE_W+GAIN_FR-1:GAIN_FR]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
      d2_vld_r <= 1'b0;
      d3_vld_r <= 1'b0;
      d4_vld_r <= 1'b0;
      d5_vld_r <= 1'b0;
      d6_vld_r <= 1'b0;
    end else if (en) begin
      d1_vld_r <= dv2_vld;
      d2_vld_r <= d1_vld_r;
      d3_vld_r <= d2_vld_r;
      d4_vld_r <= d3_vld_r;
      d5_vld_r <= d4_vld_r;
      d6_vld_r <= d5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_vref_r   <= d1_vref_nxt;
      d1_dh_r     <= d1_dh_nxt;
      d1_side_r   <= d1_side_nxt;
      d2_vref_r   <= d1_vref_r;
      d2_rnd_r    <= d2_rnd_nxt;
      d2_side_r   <= d1_side_r;
      d3_ep_r     <= d3_ep_nxt;
      d3_ev_r     <= d3_ev_nxt;
      d4_pp_r     <= d4_pp_nxt;
      d4_pvl_r    <= d4_pvl_nxt;
      d4_pvh_r    <= d4_pvh_nxt;
      d5_acc_r    <= d5_acc_nxt;
      d6_torque_r <= d6_torque_nxt;
      d6_sat_r    <= d6_sat_nxt;
    end
  end

  // Two-entry output buffer.
  logic [1:0]                 buf_cnt_r;
  logic [1:0]                 buf_cnt_nxt;
  logic signed [TORQUE_W-1:0] head_torque_r;
  logic                       head_sat_r;
  logic signed [TORQUE_W-1:0] skid_torque_r;
  logic                       skid_sat_r;
  logic signed [TORQUE_W-1:0] head_torque_nxt;
  logic                       head_sat_nxt;
  logic signed [TORQUE_W-1:0] skid_torque_nxt;
  logic                       skid_sat_nxt;
  logic                       push;
  logic                       pop;

  assign en        = (buf_cnt_r != BUF_FULL);
  assign push      = en && d6_vld_r;
  assign out_valid = (buf_cnt_r != BUF_EMPTY);
  assign pop       = out_valid && out_ready;

  always_comb begin
    buf_cnt_nxt     = buf_cnt_r;
    head_torque_nxt = head_torque_r;
    head_sat_nxt    = head_sat_r;
    skid_torque_nxt = skid_torque_r;
    skid_sat_nxt    = skid_sat_r;
    case ({push, pop})
      2'b10: begin
        buf_cnt_nxt = buf_cnt_r + 2'd1;
        if (buf_cnt_r == BUF_EMPTY) begin
          head_torque_nxt = d6_torque_r;
          head_sat_nxt    = d6_sat_r;
        end else begin
          skid_torque_nxt = d6_torque_r;
          skid_sat_nxt    = d6_sat_r;
        end
      end
      2'b01: begin
        buf_cnt_nxt = buf_cnt_r - 2'd1;
        if (buf_cnt_r == BUF_FULL) begin
          head_torque_nxt = skid_torque_r;
          head_sat_nxt    = skid_sat_r;
        end
      end
      2'b11: begin
        head_torque_nxt = d6_torque_r;
        head_sat_nxt    = d6_sat_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= BUF_EMPTY;
    end else begin
      buf_cnt_r <= buf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_torque_r <= head_torque_nxt;
    head_sat_r    <= head_sat_nxt;
    skid_torque_r <= skid_torque_nxt;
    skid_sat_r    <= skid_sat_nxt;
  end

  assign in_ready      = en;
  assign out_torque    = head_torque_r;
  assign out_saturated = head_sat_r;

endmodule
